// File: sv/rled_pkg.sv
package rled_pkg;

   // Decoder mode, one-hot
   typedef enum logic [2:0] {
      MODE_LITERAL = 3'b001,
      MODE_ESCAPED = 3'b010,
      MODE_DIGITS  = 3'b100
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SATURATED = 2'd1,
      STATUS_NO_DIGITS = 2'd2
   } status_type;

   localparam logic [7:0]  EscapeReset  = 8'd42;
   localparam logic [7:0]  DigitFirst   = 8'h30;
   localparam logic [7:0]  DigitLast    = 8'h39;
   localparam logic [15:0] LiteralRun   = 16'd1;
   localparam logic [15:0] ErrorRun     = 16'd0;

   // One result beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] run_length;
      status_type  status;
   } result_type;

endpackage

// File: sv/run_length_escape_decoder_unit.sv
// A result beat is registered in the output register, or in the skid entry if that is held.
// Throughput: one input beat per cycle while req_stall is low; the output register plus
// one skid entry let a new byte enter while a finished result waits on rsp_stall.
// Reset (synchronous, active high): literal mode, count cleared, escape byte 42,
// output and skid empty.
module run_length_escape_decoder_unit
   import rled_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_run_length,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // Count width is capped by the 16-bit run length field
   localparam int CntW = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
   localparam int ProdW = CntW + 4;
   localparam logic [CntW-1:0] CountLimit = '1;

   logic [7:0]      escape_ff;
   mode_type        mode_ff, mode_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            sat_ff, sat_in;

   logic            out_valid_ff, out_valid_in;
   result_type      out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   result_type      skid_ff, skid_in;

   logic            accept, is_digit, has_result, out_take, out_free;
   logic [ProdW-1:0] prod, next_count;
   result_type      result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign is_digit  = (req_in_byte >= DigitFirst) && (req_in_byte <= DigitLast);

   // Accumulate the decimal count: count * 10 + digit
   assign prod = ProdW'({count_ff, 3'b000}) + ProdW'({count_ff, 1'b0});
   always_comb begin
      if (mode_ff == MODE_ESCAPED) begin
         next_count = ProdW'(req_in_byte[3:0]);
      end else begin
         next_count = prod + ProdW'(req_in_byte[3:0]);
      end
   end

   // Decode one byte
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      sat_in     = sat_ff;
      has_result = 1'b0;
      result     = '{out_byte: req_in_byte, run_length: LiteralRun, status: STATUS_OK};
      unique case (mode_ff)
         MODE_LITERAL: begin
            if (req_in_byte == escape_ff) begin
               mode_in  = MODE_ESCAPED;
               count_in = '0;
               sat_in   = 1'b0;
            end else begin
               has_result = 1'b1;
            end
         end
         MODE_ESCAPED, MODE_DIGITS: begin
            if (is_digit) begin
               mode_in = MODE_DIGITS;
               if (next_count > ProdW'(CountLimit)) begin
                  count_in = CountLimit;
                  sat_in   = 1'b1;
               end else begin
                  count_in = next_count[CntW-1:0];
               end
            end else begin
               has_result = 1'b1;
               if (mode_ff == MODE_DIGITS) begin
                  result.run_length = 16'(count_ff);
                  result.status     = sat_ff ? STATUS_SATURATED : STATUS_OK;
               end else begin
                  result.run_length = ErrorRun;
                  result.status     = STATUS_NO_DIGITS;
               end
               mode_in  = MODE_LITERAL;
               count_in = '0;
               sat_in   = 1'b0;
            end
         end
         default: begin
            mode_in  = MODE_LITERAL;
            count_in = '0;
            sat_in   = 1'b0;
         end
      endcase
   end

   // Output register with one skid entry
   assign out_take = out_valid_ff & ~rsp_stall;
   assign out_free = ~out_valid_ff | out_take;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && has_result) begin
         if (out_free) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff     <= EscapeReset;
         mode_ff       <= MODE_LITERAL;
         count_ff      <= '0;
         sat_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            escape_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            sat_ff   <= sat_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_ff.out_byte;
   assign rsp_run_length = out_ff.run_length;
   assign rsp_status     = out_ff.status;

endmodule
